// ===== rtl/formula_lexer_defines.svh =====
// Assertion macros used by the lexer back end.
`ifndef FORMULA_LEXER_DEFINES_SVH
`define FORMULA_LEXER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define FLX_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define FLX_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/flx_pkg.sv =====
package flx_pkg;

  localparam int LengthBitsDefault = 16;
  localparam int NestBitsDefault   = 8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_type;
    logic [15:0] token_length;
    logic [2:0]  error_kind;
    logic        last_result;
  } out_item_t;

  // Lexer modes.
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_STR    = 4'd1;
  localparam logic [3:0] M_QDELIM = 4'd2;
  localparam logic [3:0] M_QNEST  = 4'd3;
  localparam logic [3:0] M_CMP    = 4'd4;
  localparam logic [3:0] M_DASH   = 4'd5;
  localparam logic [3:0] M_ZERO   = 4'd6;
  localparam logic [3:0] M_HEX    = 4'd7;
  localparam logic [3:0] M_INT    = 4'd8;
  localparam logic [3:0] M_DEC    = 4'd9;
  localparam logic [3:0] M_WS     = 4'd10;
  localparam logic [3:0] M_QSTART = 4'd11;
  localparam logic [3:0] M_DSEEN  = 4'd12;
  localparam logic [3:0] M_IDENT  = 4'd13;

  // Token types.
  localparam logic [4:0] T_OP      = 5'd9;
  localparam logic [4:0] T_STR     = 5'd10;
  localparam logic [4:0] T_COMMENT = 5'd11;
  localparam logic [4:0] T_PTR     = 5'd12;
  localparam logic [4:0] T_INT     = 5'd13;
  localparam logic [4:0] T_DEC     = 5'd14;
  localparam logic [4:0] T_WS      = 5'd15;
  localparam logic [4:0] T_KW      = 5'd16;
  localparam logic [4:0] T_ID      = 5'd17;
  localparam logic [4:0] T_CID     = 5'd18;

  // Error codes.
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_UNTERM = 3'd1;
  localparam logic [2:0] E_QUNTERM = 3'd2;
  localparam logic [2:0] E_BANG  = 3'd3;
  localparam logic [2:0] E_BADCH = 3'd4;
  localparam logic [2:0] E_NEST  = 3'd5;

  // Character classes found by the front end.
  typedef struct packed {
    logic digit;
    logic lower;
    logic alpha;
    logic space;
    logic xdigit;
    logic identch;
    logic [4:0] punct;
    logic is_punct;
  } char_class_t;

  // Word table: character at a position of each keyword / word operator.
  function automatic logic [7:0] word_char(input logic [2:0] k, input logic [3:0] pos);
    logic [7:0] r;
    r = 8'd0;
    unique case (k)
      3'd0: begin
        case (pos)
          4'd0: r = "f"; 4'd1: r = "u"; 4'd2: r = "n"; 4'd3: r = "c"; 4'd4: r = "t";
          4'd5: r = "i"; 4'd6: r = "o"; 4'd7: r = "n"; 4'd8: r = "s";
          default: r = 8'd0;
        endcase
      end
      3'd1: begin
        case (pos)
          4'd0: r = "d"; 4'd1: r = "e"; 4'd2: r = "f"; default: r = 8'd0;
        endcase
      end
      3'd2: begin
        case (pos)
          4'd0: r = "n"; 4'd1: r = "u"; 4'd2: r = "l"; 4'd3: r = "l"; default: r = 8'd0;
        endcase
      end
      3'd3: begin
        case (pos)
          4'd0: r = "n"; 4'd1: r = "o"; 4'd2: r = "t"; default: r = 8'd0;
        endcase
      end
      3'd4: begin
        case (pos)
          4'd0: r = "a"; 4'd1: r = "n"; 4'd2: r = "d"; default: r = 8'd0;
        endcase
      end
      3'd5: begin
        case (pos)
          4'd0: r = "o"; 4'd1: r = "r"; default: r = 8'd0;
        endcase
      end
      3'd6: begin
        case (pos)
          4'd0: r = "w"; 4'd1: r = "h"; 4'd2: r = "e"; 4'd3: r = "r"; 4'd4: r = "e";
          default: r = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          4'd0: r = "i"; 4'd1: r = "n"; default: r = 8'd0;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_len(input logic [2:0] k);
    logic [3:0] r;
    unique case (k)
      3'd0: r = 4'd9;
      3'd1: r = 4'd3;
      3'd2: r = 4'd4;
      3'd3: r = 4'd3;
      3'd4: r = 4'd3;
      3'd5: r = 4'd2;
      3'd6: r = 4'd5;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/flx_front.sv =====
// Accepts bytes, classifies them and forwards byte plus class to the queue.
module flx_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  flx_pkg::in_item_t     in_item,
  output logic                  cls_valid,
  input  logic                  cls_stall,
  output flx_pkg::in_item_t     cls_item,
  output flx_pkg::char_class_t  cls_class
);

  flx_pkg::char_class_t cc;
  logic [7:0] c;

  assign c = in_item.char_code;

  always_comb begin
    cc.digit   = (c >= "0") && (c <= "9");
    cc.lower   = (c >= "a") && (c <= "z");
    cc.alpha   = cc.lower || ((c >= "A") && (c <= "Z"));
    cc.space   = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    cc.xdigit  = cc.digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    cc.identch = cc.alpha || cc.digit || (c == "_");
    cc.is_punct = 1'b1;
    case (c)
      "(": cc.punct = 5'd0;
      ")": cc.punct = 5'd1;
      "[": cc.punct = 5'd2;
      "]": cc.punct = 5'd3;
      "{": cc.punct = 5'd4;
      "}": cc.punct = 5'd5;
      ",": cc.punct = 5'd6;
      ";": cc.punct = 5'd7;
      ":": cc.punct = 5'd8;
      ".", "+", "*", "/", "=", "%", "^": cc.punct = flx_pkg::T_OP;
      default: begin
        cc.punct = 5'd0;
        cc.is_punct = 1'b0;
      end
    endcase
  end

  // Single register stage; takes a new byte whenever the stage is empty or drains.
  assign in_stall = cls_valid && cls_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (!in_stall) begin
      cls_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cls_item  <= in_item;
      cls_class <= cc;
    end
  end

endmodule

// ===== rtl/flx_queue.sv =====
// Two-entry queue between front and back end.
module flx_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

endmodule

// ===== rtl/flx_back.sv =====
// Lexer state machine. Takes one classified byte per cycle while the result
// buffer has room, and produces up to two results into a small output buffer.
`include "formula_lexer_defines.svh"
module flx_back #(
  parameter int LengthBits = flx_pkg::LengthBitsDefault,
  parameter int NestBits   = flx_pkg::NestBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_stall,
  input  flx_pkg::in_item_t     q_item,
  input  flx_pkg::char_class_t  q_class,
  output logic                  out_valid,
  input  logic                  out_stall,
  output flx_pkg::out_item_t    out_item
);

  localparam logic [LengthBits-1:0] LenMax  = {LengthBits{1'b1}};
  localparam logic [NestBits-1:0]   NestMax = {NestBits{1'b1}};

  // State registers.
  logic [3:0]            lex_mode;
  logic [LengthBits-1:0] run_length;
  logic [7:0]            closing_char;
  logic [7:0]            opening_char;
  logic [NestBits-1:0]   nest_depth;
  logic [7:0]            word_match_mask;
  logic                  saw_lowercase;

  logic [3:0]            lex_mode_next;
  logic [LengthBits-1:0] run_length_next;
  logic [7:0]            closing_char_next;
  logic [7:0]            opening_char_next;
  logic [NestBits-1:0]   nest_depth_next;
  logic [7:0]            word_match_mask_next;
  logic                  saw_lowercase_next;

  // Result buffer: up to two pending entries.
  flx_pkg::out_item_t buf0;
  flx_pkg::out_item_t buf1;
  logic [1:0]         buf_count;

  flx_pkg::out_item_t res [2];
  logic [1:0]         res_n;

  logic       take;
  logic       pop;
  logic [7:0] c;
  flx_pkg::char_class_t k;

  assign c = q_item.char_code;
  assign k = q_class;
  assign out_valid = (buf_count != 2'd0);
  assign out_item  = buf0;
  assign pop  = out_valid && !out_stall;
  // Accept a byte only when the buffer can take two results after this pop.
  assign q_stall = (buf_count == 2'd2) || ((buf_count == 2'd1) && !pop);
  assign take = q_valid && !q_stall;

  function automatic logic [15:0] sat16(input logic [LengthBits-1:0] v);
    logic [15:0] r;
    if (LengthBits > 16) begin
      r = (v > LengthBits'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic logic [LengthBits-1:0] grow(input logic [LengthBits-1:0] v);
    return (v == LenMax) ? v : v + LengthBits'(1);
  endfunction

  // Combinational step of the lexer; done as one pass with an optional retry
  // of the byte when it closed the pending token, then an end-of-text flush.
  always_comb begin
    logic [3:0]            m;
    logic [LengthBits-1:0] rl;
    logic [7:0]            cl;
    logic [7:0]            op;
    logic [NestBits-1:0]   nd;
    logic [7:0]            wm;
    logic                  sl;
    logic                  taken;
    logic                  pass;
    logic [4:0]            tt;
    logic                  hit;
    logic [1:0]            n;
    flx_pkg::out_item_t    r [2];

    m = lex_mode; rl = run_length; cl = closing_char; op = opening_char;
    nd = nest_depth; wm = word_match_mask; sl = saw_lowercase;
    n = 2'd0;
    r[0] = '0;
    r[1] = '0;
    taken = 1'b0;
    tt = 5'd0;
    hit = 1'b0;

    for (int p = 0; p < 3; p++) begin
      pass = (p < 2) ? !taken : 1'b0;
      // Third pass: end-of-text flush.
      if (p == 2 && q_item.end_of_text) begin
        tt = 5'd0;
        hit = 1'b0;
        unique case (m)
          flx_pkg::M_QSTART, flx_pkg::M_DSEEN, flx_pkg::M_IDENT: begin
            tt = sl ? flx_pkg::T_ID : flx_pkg::T_CID;
            for (int j = 0; j < 8; j++) begin
              if (!hit && wm[j] && rl == LengthBits'(flx_pkg::word_len(3'(j)))) begin
                tt = (j < 3) ? flx_pkg::T_KW : flx_pkg::T_OP;
                hit = 1'b1;
              end
            end
            r[n[0]] = '{tt, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_CMP: begin
            if (op == "!") r[n[0]] = '{5'd0, sat16(rl), flx_pkg::E_BANG, 1'b0};
            else r[n[0]] = '{flx_pkg::T_OP, sat16(rl), flx_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
          end
          flx_pkg::M_DASH: begin
            r[n[0]] = '{flx_pkg::T_OP, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_ZERO, flx_pkg::M_HEX, flx_pkg::M_INT: begin
            r[n[0]] = '{flx_pkg::T_INT, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_DEC: begin
            r[n[0]] = '{flx_pkg::T_DEC, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_WS: begin
            r[n[0]] = '{flx_pkg::T_WS, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_STR: begin
            r[n[0]] = '{5'd0, sat16(rl), flx_pkg::E_UNTERM, 1'b0}; n = n + 2'd1;
          end
          flx_pkg::M_QDELIM, flx_pkg::M_QNEST: begin
            r[n[0]] = '{5'd0, sat16(rl), flx_pkg::E_QUNTERM, 1'b0}; n = n + 2'd1;
          end
          default: ;
        endcase
        m = flx_pkg::M_IDLE;
      end else if (pass) begin
        // Mode after a closing pass for the idle-restart semantics.
        taken = 1'b1;
        unique case (m)
          flx_pkg::M_IDLE: begin
            rl = LengthBits'(1);
            if (k.is_punct) begin
              r[n[0]] = '{k.punct, 16'd1, flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
            end else if (c == "'" || c == "~" || c == "#") begin
              cl = c; m = flx_pkg::M_STR;
            end else if (c == "q" || c == "d" || k.alpha || c == "_") begin
              wm = 8'hFF;
              for (int j = 0; j < 8; j++) begin
                if (flx_pkg::word_char(3'(j), 4'd0) != c) wm[j] = 1'b0;
              end
              sl = k.lower;
              m = (c == "q") ? flx_pkg::M_QSTART :
                  (c == "d") ? flx_pkg::M_DSEEN : flx_pkg::M_IDENT;
            end else if (c == "<" || c == ">" || c == "!") begin
              op = c; m = flx_pkg::M_CMP;
            end else if (c == "-") begin
              m = flx_pkg::M_DASH;
            end else if (c == "0") begin
              m = flx_pkg::M_ZERO;
            end else if (k.space) begin
              m = flx_pkg::M_WS;
            end else if (k.digit) begin
              m = flx_pkg::M_INT;
            end else begin
              r[n[0]] = '{5'd0, 16'd1, flx_pkg::E_BADCH, 1'b0}; n = n + 2'd1;
            end
          end
          flx_pkg::M_STR: begin
            rl = grow(rl);
            if (c == cl) begin
              r[n[0]] = '{(cl == "#") ? flx_pkg::T_COMMENT : flx_pkg::T_STR, sat16(rl),
                          flx_pkg::E_NONE, 1'b0};
              n = n + 2'd1;
              m = flx_pkg::M_IDLE;
            end
          end
          flx_pkg::M_QDELIM: begin
            rl = grow(rl);
            if (c == cl) begin
              r[n[0]] = '{flx_pkg::T_STR, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
              m = flx_pkg::M_IDLE;
            end
          end
          flx_pkg::M_QNEST: begin
            rl = grow(rl);
            if (c == op) begin
              if (nd == NestMax) begin
                r[n[0]] = '{5'd0, sat16(rl), flx_pkg::E_NEST, 1'b0}; n = n + 2'd1;
                m = flx_pkg::M_IDLE;
              end else begin
                nd = nd + NestBits'(1);
              end
            end else if (c == cl) begin
              if (nd <= NestBits'(1)) begin
                nd = '0;
                r[n[0]] = '{flx_pkg::T_STR, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
                m = flx_pkg::M_IDLE;
              end else begin
                nd = nd - NestBits'(1);
              end
            end
          end
          flx_pkg::M_CMP: begin
            if (c == "=") begin
              rl = grow(rl);
              r[n[0]] = '{flx_pkg::T_OP, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
            end else begin
              if (op == "!") r[n[0]] = '{5'd0, sat16(rl), flx_pkg::E_BANG, 1'b0};
              else r[n[0]] = '{flx_pkg::T_OP, sat16(rl), flx_pkg::E_NONE, 1'b0};
              n = n + 2'd1;
              taken = 1'b0;
            end
            m = flx_pkg::M_IDLE;
          end
          flx_pkg::M_DASH: begin
            if (c == ">") begin
              rl = grow(rl);
              r[n[0]] = '{flx_pkg::T_PTR, sat16(rl), flx_pkg::E_NONE, 1'b0};
            end else begin
              r[n[0]] = '{flx_pkg::T_OP, sat16(rl), flx_pkg::E_NONE, 1'b0};
              taken = 1'b0;
            end
            n = n + 2'd1;
            m = flx_pkg::M_IDLE;
          end
          flx_pkg::M_ZERO, flx_pkg::M_INT: begin
            if (m == flx_pkg::M_ZERO && c == "x") begin
              rl = grow(rl); m = flx_pkg::M_HEX;
            end else if (k.digit) begin
              rl = grow(rl); m = flx_pkg::M_INT;
            end else if (c == ".") begin
              rl = grow(rl); m = flx_pkg::M_DEC;
            end else begin
              r[n[0]] = '{flx_pkg::T_INT, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
              m = flx_pkg::M_IDLE; taken = 1'b0;
            end
          end
          flx_pkg::M_HEX, flx_pkg::M_DEC, flx_pkg::M_WS: begin
            if ((m == flx_pkg::M_HEX && k.xdigit) || (m == flx_pkg::M_DEC && k.digit) ||
                (m == flx_pkg::M_WS && k.space)) begin
              rl = grow(rl);
            end else begin
              r[n[0]] = '{(m == flx_pkg::M_DEC) ? flx_pkg::T_DEC :
                          (m == flx_pkg::M_WS) ? flx_pkg::T_WS : flx_pkg::T_INT,
                          sat16(rl), flx_pkg::E_NONE, 1'b0};
              n = n + 2'd1;
              m = flx_pkg::M_IDLE; taken = 1'b0;
            end
          end
          flx_pkg::M_DSEEN: begin
            if (k.alpha) begin
              for (int j = 0; j < 8; j++) begin
                if (rl >= LengthBits'(flx_pkg::word_len(3'(j))) ||
                    flx_pkg::word_char(3'(j), rl[3:0]) != c) wm[j] = 1'b0;
              end
              if (k.lower) sl = 1'b1;
              rl = grow(rl);
              m = flx_pkg::M_IDENT;
            end else begin
              r[n[0]] = '{flx_pkg::T_OP, 16'd1, flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
              m = flx_pkg::M_IDLE; taken = 1'b0;
            end
          end
          flx_pkg::M_QSTART, flx_pkg::M_IDENT: begin
            if (m == flx_pkg::M_QSTART && (c == "~" || c == "#" || c == "^")) begin
              rl = grow(rl); cl = c; m = flx_pkg::M_QDELIM;
            end else if (m == flx_pkg::M_QSTART && (c == "(" || c == "[" || c == "{")) begin
              rl = grow(rl); op = c;
              cl = (c == "(") ? ")" : ((c == "[") ? "]" : "}");
              nd = NestBits'(1);
              m = flx_pkg::M_QNEST;
            end else if (k.identch) begin
              for (int j = 0; j < 8; j++) begin
                if (rl >= LengthBits'(flx_pkg::word_len(3'(j))) ||
                    flx_pkg::word_char(3'(j), rl[3:0]) != c) wm[j] = 1'b0;
              end
              if (k.lower) sl = 1'b1;
              rl = grow(rl);
              m = flx_pkg::M_IDENT;
            end else begin
              tt = sl ? flx_pkg::T_ID : flx_pkg::T_CID;
              hit = 1'b0;
              for (int j = 0; j < 8; j++) begin
                if (!hit && wm[j] && rl == LengthBits'(flx_pkg::word_len(3'(j)))) begin
                  tt = (j < 3) ? flx_pkg::T_KW : flx_pkg::T_OP;
                  hit = 1'b1;
                end
              end
              r[n[0]] = '{tt, sat16(rl), flx_pkg::E_NONE, 1'b0}; n = n + 2'd1;
              m = flx_pkg::M_IDLE; taken = 1'b0;
            end
          end
          default: begin
            m = flx_pkg::M_IDLE; taken = 1'b0;
          end
        endcase
      end
    end

    if (n == 2'd1) r[0].last_result = 1'b1;
    if (n == 2'd2) r[1].last_result = 1'b1;
    res[0] = r[0];
    res[1] = r[1];
    res_n  = n;
    lex_mode_next = m; run_length_next = rl; closing_char_next = cl;
    opening_char_next = op; nest_depth_next = nd; word_match_mask_next = wm;
    saw_lowercase_next = sl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= flx_pkg::M_IDLE;
      run_length      <= '0;
      closing_char    <= 8'd0;
      opening_char    <= 8'd0;
      nest_depth      <= '0;
      word_match_mask <= 8'hFF;
      saw_lowercase   <= 1'b0;
    end else if (take) begin
      lex_mode        <= lex_mode_next;
      run_length      <= run_length_next;
      closing_char    <= closing_char_next;
      opening_char    <= opening_char_next;
      nest_depth      <= nest_depth_next;
      word_match_mask <= word_match_mask_next;
      saw_lowercase   <= saw_lowercase_next;
    end
  end

  // Output buffer. A byte is taken only when no entry stays after a pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else begin
      buf_count <= buf_count - {1'b0, pop} + (take ? res_n : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (buf_count == 2'd2) begin
        buf0 <= buf1;
      end else if (take) begin
        buf0 <= res[0];
        buf1 <= res[1];
      end
    end else if (take) begin
      if (buf_count == 2'd0) begin
        buf0 <= res[0];
        buf1 <= res[1];
      end
    end
  end

  `FLX_ASSERT_IMP(a_buf_bound, clk, rst, 1'b1, buf_count <= 2'd2, "result buffer overflow")
  `FLX_ASSERT_IMP(a_take_room, clk, rst, take, buf_count == 2'd0 || pop,
                  "byte taken without room for results")
  `FLX_ASSERT_NEXT(a_idle_nest, clk, rst, take && lex_mode_next == flx_pkg::M_QDELIM,
                   lex_mode == flx_pkg::M_QDELIM, "mode update lost")

endmodule

// ===== rtl/formula_lexer.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | flx_pkg::in_item_t (char_code, end_of_text)
// out     | output    | out_valid/out_stall| flx_pkg::out_item_t (type, length, error, last)
//
// One byte per cycle is sustained while each byte yields one result and out
// is not stalled; a byte passes the input register, the two-entry queue and
// the lexer step into the result buffer. The lexer step is the single state
// loop that sets the rate. Reset is synchronous and clears all control state
// and the lexer mode. A byte that yields two results holds the lexer while the
// second result drains; the queue buffers stalls on either side until it fills.
module formula_lexer #(
  parameter int LengthBits = flx_pkg::LengthBitsDefault,
  parameter int NestBits   = flx_pkg::NestBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  flx_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output flx_pkg::out_item_t  out_item
);

  localparam int QWidth = $bits(flx_pkg::in_item_t) + $bits(flx_pkg::char_class_t);

  logic                 cls_valid;
  logic                 cls_stall;
  flx_pkg::in_item_t    cls_item;
  flx_pkg::char_class_t cls_class;
  logic                 q_valid;
  logic                 q_stall;
  logic [QWidth-1:0]    q_data;

  // Front end: byte register and character classification.
  flx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cls_valid (cls_valid),
    .cls_stall (cls_stall),
    .cls_item  (cls_item),
    .cls_class (cls_class)
  );

  // Decoupling queue so the lexer can stall on a double result.
  flx_queue #(.Width(QWidth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cls_valid),
    .wr_stall (cls_stall),
    .wr_data  ({cls_item, cls_class}),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_data)
  );

  // Back end: lexer state and result buffer.
  flx_back #(.LengthBits(LengthBits), .NestBits(NestBits)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_item    (q_data[QWidth-1 -: $bits(flx_pkg::in_item_t)]),
    .q_class   (q_data[$bits(flx_pkg::char_class_t)-1:0]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
